>>> hdl/circular_deque_with_search_macros.svh
// Assertion macros shared by the checker.
`ifndef CIRCULAR_DEQUE_WITH_SEARCH_MACROS_SVH
`define CIRCULAR_DEQUE_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CDWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cdws_pkg.sv
package cdws_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_FRONT   = 2'd0,
        OP_TAIL    = 2'd1,
        OP_SEARCH  = 2'd2,
        OP_ADVANCE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_ADV,
        S_DONE
    } t_state;

    // Position base + off on the ring, with both operands below CAPACITY.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(CAPACITY)) begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

>>> hdl/cdws_if.sv
interface cdws_in_if import cdws_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           opcode;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface cdws_out_if import cdws_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic signed [VALUE_W-1:0] head_value;
    logic [COUNT_W-1:0]        count;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output found, output head_value, output count,
                    output status, input ready);
    modport sink   (input valid, input found, input head_value, input count,
                    input status, output ready);
endinterface

>>> hdl/circular_deque_with_search.sv
// An insert or a refused operation runs through the states EXEC and DONE, an advance through
// EXEC, ADV and DONE, and a search through EXEC, one SCAN step per stored element read, and DONE.
// One item is in flight at a time; a search reads the stored elements in turn because the
// single read port of the element RAM delivers one element per cycle.
// Synchronous active-low reset empties the list and sets the head to position zero;
// the element RAM is not cleared.
module circular_deque_with_search import cdws_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdws_in_if.sink    i_in,
    cdws_out_if.source o_out
);

    t_state                    r_state, n_state;
    t_op                       r_op, n_op;
    logic [VALUE_W-1:0]        r_val, n_val;
    logic [IDX_W-1:0]          r_head, n_head;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [VALUE_W-1:0]        r_head_val, n_head_val;
    logic [IDX_W-1:0]          r_scan, n_scan;
    logic                      r_found, n_found;
    t_status                   r_status, n_status;

    logic                      r_out_valid;
    logic                      r_out_found;
    logic [VALUE_W-1:0]        r_out_head;
    logic [COUNT_W-1:0]        r_out_count;
    t_status                   r_out_status;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic                      ram_re;
    logic [IDX_W-1:0]          ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;
    logic                      load_out;
    logic                      slot_free;
    logic                      is_full;
    logic                      is_empty;
    logic                      scan_last;

    cdws_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(r_val),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign slot_free = !r_out_valid || o_out.ready;
    assign is_full   = (r_count == CNT_W'(CAPACITY));
    assign is_empty  = (r_count == '0);
    assign scan_last = ((CNT_W'(r_scan) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_val      = r_val;
        n_head     = r_head;
        n_count    = r_count;
        n_head_val = r_head_val;
        n_scan     = r_scan;
        n_found    = r_found;
        n_status   = r_status;
        ram_we     = 1'b0;
        ram_waddr  = r_head;
        ram_re     = 1'b0;
        ram_raddr  = r_head;
        load_out   = 1'b0;
        i_in.ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = i_rst_n;
                if (i_in.valid) begin
                    n_op    = t_op'(i_in.opcode);
                    n_val   = i_in.value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_found  = 1'b0;
                n_status = ST_OK;
                unique case (r_op)
                    OP_FRONT, OP_TAIL: begin
                        n_state = S_DONE;
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            if (r_op == OP_FRONT) begin
                                ram_waddr  = ring_add(r_head, IDX_W'(CAPACITY - 1));
                                n_head     = ram_waddr;
                                n_head_val = r_val;
                            end else begin
                                ram_waddr = ring_add(r_head, r_count[IDX_W-1:0]);
                                if (is_empty) begin
                                    n_head_val = r_val;
                                end
                            end
                        end
                    end
                    OP_SEARCH: begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = r_head;
                            n_scan    = '0;
                            n_state   = S_SCAN;
                        end
                    end
                    OP_ADVANCE: begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = ring_add(r_head, IDX_W'(1));
                            n_head    = ram_raddr;
                            n_count   = r_count - CNT_W'(1);
                            n_state   = S_ADV;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (ram_rdata == r_val) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (scan_last) begin
                    n_state = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ring_add(r_head, r_scan + IDX_W'(1));
                    n_scan    = r_scan + IDX_W'(1);
                end
            end
            S_ADV: begin
                n_head_val = ram_rdata;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_head_val <= n_head_val;
        r_scan     <= n_scan;
        r_found    <= n_found;
        r_status   <= n_status;
        if (load_out) begin
            r_out_found  <= r_found;
            r_out_head   <= is_empty ? '0 : r_head_val;
            r_out_count  <= COUNT_W'(r_count);
            r_out_status <= r_status;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.found      = r_out_found;
    assign o_out.head_value = r_out_head;
    assign o_out.count      = r_out_count;
    assign o_out.status     = r_out_status;

endmodule

>>> hdl/cdws_ram.sv
module cdws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/cdws_checker.sv
`include "circular_deque_with_search_macros.svh"

module cdws_checker import cdws_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_out_found,
    input logic signed [VALUE_W-1:0] i_out_head_value,
    input logic [COUNT_W-1:0]        i_out_count,
    input logic [STATUS_W-1:0]       i_out_status
);

    // A stalled result beat keeps its valid and its payload.
    `CDWS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_out_found, i_out_head_value, i_out_count, i_out_status}), "result beat changed while stalled")

    // A refused insert only happens on a full list.
    `CDWS_ASSERT_IMP(a_full_count, i_clk, i_rst_n, i_out_valid && (i_out_status == ST_FULL), i_out_count == COUNT_W'(CAPACITY), "full status with a list that is not full")

    // An empty list reports a zero head and no match.
    `CDWS_ASSERT_IMP(a_empty_head, i_clk, i_rst_n, i_out_valid && (i_out_count == '0), (i_out_head_value == '0) && !i_out_found, "empty list with a head value or a match")

    // A match implies a successful search.
    `CDWS_ASSERT_IMP(a_found_ok, i_clk, i_rst_n, i_out_valid && i_out_found, i_out_status == ST_OK, "match reported with an error status")

endmodule

bind circular_deque_with_search cdws_checker u_cdws_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_found     (o_out.found),
    .i_out_head_value(o_out.head_value),
    .i_out_count     (o_out.count),
    .i_out_status    (o_out.status)
);
